>>> rtl/tekd_pkg.sv
// tekd_pkg: types, byte codes and key codes for the terminal escape key decoder
// no dependencies; used by the interfaces and every rtl module
package tekd_pkg;

	localparam int unsigned CFG_W = 8;
	localparam logic [CFG_W-1:0] TIMEOUT_RESET = 8'd25;

	// request kinds
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// event kinds
	localparam logic EVT_KEY   = 1'b0;
	localparam logic EVT_BREAK = 1'b1;

	// control bytes
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SS3   = 8'h4f; // 'O'
	localparam logic [7:0] CH_CSI   = 8'h5b; // '['
	localparam logic [7:0] CH_TILDE = 8'h7e;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_2     = 8'h32;
	localparam logic [7:0] CH_3     = 8'h33;
	localparam logic [7:0] CH_5     = 8'h35;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_8     = 8'h38;
	localparam logic [7:0] CH_9     = 8'h39;

	// key codes
	localparam logic [7:0] KEY_F1    = 8'h81;
	localparam logic [7:0] KEY_UP    = 8'hb5;
	localparam logic [7:0] KEY_DOWN  = 8'hb6;
	localparam logic [7:0] KEY_RIGHT = 8'hb7;
	localparam logic [7:0] KEY_LEFT  = 8'hb4;
	localparam logic [7:0] KEY_HOME  = 8'hd2;
	localparam logic [7:0] KEY_END   = 8'hd5;
	localparam logic [7:0] KEY_DELETE = 8'hd4;
	localparam logic [7:0] KEY_F5    = 8'h85;
	localparam logic [7:0] KEY_F6    = 8'h86;
	localparam logic [7:0] KEY_F7    = 8'h87;
	localparam logic [7:0] KEY_F8    = 8'h88;
	localparam logic [7:0] KEY_F9    = 8'h89;
	localparam logic [7:0] KEY_F10   = 8'h90;

	localparam int unsigned SEQ_DEPTH = 4;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic       event_kind;
		logic [7:0] key_code;
	} evt_t;

	// one processed request: whether it yields an event, and the event
	typedef struct packed {
		logic has_evt;
		evt_t evt;
	} res_t;

endpackage

>>> rtl/tekd_if.sv
// tekd_if: valid/ready channels for requests and key events
// depends on tekd_pkg
interface tekd_req_if import tekd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] rx_byte;

	modport source(output valid, output req_type, output rx_byte, input ready);
	modport sink(input valid, input req_type, input rx_byte, output ready);
endinterface

interface tekd_evt_if import tekd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       event_kind;
	logic [7:0] key_code;

	modport source(output valid, output event_kind, output key_code, input ready);
	modport sink(input valid, input event_kind, input key_code, output ready);
endinterface

>>> rtl/tekd_in_stage.sv
// tekd_in_stage: input register for one request, refilled every cycle it drains
// depends on tekd_pkg
module tekd_in_stage import tekd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	input  logic advance,
	output logic valid_s1,
	output req_t req_s1
);

	logic valid_q;

	assign in_ready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_req;
		end
	end

endmodule

>>> rtl/tekd_decoder.sv
// tekd_decoder: escape sequence state, timeout counter, timeout register and key decode
// depends on tekd_pkg
module tekd_decoder import tekd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             fire,
	input  req_t             req,
	output res_t             res
);

	typedef struct packed {
		logic       done;
		logic       bad;
		logic [7:0] code;
	} dec_t;

	logic [CFG_W-1:0] timeout_cfg_q;
	logic             in_escape_q;
	logic [2:0]       seq_count_q;
	logic [7:0]       timeout_left_q;
	logic [7:0]       seq_bytes_q [SEQ_DEPTH];

	logic [7:0] seq_now [SEQ_DEPTH];
	logic [1:0] wr_idx;
	logic [2:0] n_next;
	logic       count_bad;
	dec_t       dec;

	logic       in_escape_d;
	logic [2:0] seq_count_d;
	logic [7:0] timeout_left_d;

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= CH_0) && (ch <= CH_9);
	endfunction

	function automatic dec_t decode(input logic [2:0] n, input logic [7:0] a,
			input logic [7:0] b, input logic [7:0] c, input logic [7:0] d);
		dec_t r;
		r.done = 1'b1;
		r.bad  = 1'b1;
		r.code = 8'h00;
		if (a == CH_SS3) begin
			if (n == 3'd2) begin
				r.done = 1'b0;
			end else if (n == 3'd3 && b >= CH_P && b <= CH_S) begin
				r.bad  = 1'b0;
				r.code = KEY_F1 + (b - CH_P);
			end
		end else if (a == CH_CSI) begin
			case (n)
				3'd2: r.done = 1'b0;
				3'd3: begin
					r.bad = 1'b0;
					case (b)
						CH_A: r.code = KEY_UP;
						CH_B: r.code = KEY_DOWN;
						CH_C: r.code = KEY_RIGHT;
						CH_D: r.code = KEY_LEFT;
						CH_H: r.code = KEY_HOME;
						CH_F: r.code = KEY_END;
						CH_1, CH_2, CH_3: r.done = 1'b0;
						default: r.bad = 1'b1;
					endcase
				end
				3'd4: begin
					if (b == CH_3) begin
						if (c == CH_TILDE) begin
							r.bad  = 1'b0;
							r.code = KEY_DELETE;
						end
					end else if ((b == CH_1 || b == CH_2) && is_digit(c)) begin
						r.done = 1'b0;
						r.bad  = 1'b0;
					end
				end
				3'd5: begin
					if (d == CH_TILDE) begin
						r.bad = 1'b0;
						// two-digit function key numbers
						if (b == CH_1 && c == CH_5)      r.code = KEY_F5;
						else if (b == CH_1 && c == CH_7) r.code = KEY_F6;
						else if (b == CH_1 && c == CH_8) r.code = KEY_F7;
						else if (b == CH_1 && c == CH_9) r.code = KEY_F8;
						else if (b == CH_2 && c == CH_0) r.code = KEY_F9;
						else if (b == CH_2 && c == CH_1) r.code = KEY_F10;
						else                             r.bad  = 1'b1;
					end
				end
				default: r.bad = 1'b1;
			endcase
		end
		return r;
	endfunction

	assign wr_idx    = 2'(seq_count_q - 3'd1);
	assign n_next    = seq_count_q + 3'd1;
	assign count_bad = (seq_count_q == 3'd0) || (seq_count_q > 3'(SEQ_DEPTH));

	// stored bytes with the incoming byte in its slot
	always_comb begin
		for (int i = 0; i < SEQ_DEPTH; i++) begin
			seq_now[i] = (wr_idx == 2'(i)) ? req.rx_byte : seq_bytes_q[i];
		end
	end

	assign dec = decode(n_next, seq_now[0], seq_now[1], seq_now[2], seq_now[3]);

	always_comb begin
		res            = '0;
		in_escape_d    = in_escape_q;
		seq_count_d    = seq_count_q;
		timeout_left_d = timeout_left_q;
		if (req.req_type == REQ_TICK) begin
			if (in_escape_q) begin
				if (timeout_left_q <= 8'd1) begin
					timeout_left_d       = 8'd0;
					in_escape_d          = 1'b0;
					seq_count_d          = 3'd0;
					res.has_evt          = 1'b1;
					res.evt.event_kind   = EVT_BREAK;
				end else begin
					timeout_left_d = timeout_left_q - 8'd1;
				end
			end
		end else begin
			timeout_left_d = timeout_cfg_q;
			if (!in_escape_q) begin
				if (req.rx_byte == CH_ETX) begin
					res.has_evt        = 1'b1;
					res.evt.event_kind = EVT_BREAK;
				end else if (req.rx_byte == CH_ESC) begin
					in_escape_d = 1'b1;
					seq_count_d = 3'd1;
				end else begin
					res.has_evt        = 1'b1;
					res.evt.event_kind = EVT_KEY;
					res.evt.key_code   = (req.rx_byte == CH_DEL) ? CH_BS : req.rx_byte;
				end
			end else if (count_bad) begin
				in_escape_d        = 1'b0;
				seq_count_d        = 3'd0;
				res.has_evt        = 1'b1;
				res.evt.event_kind = EVT_BREAK;
			end else if (!dec.done) begin
				seq_count_d = n_next;
			end else begin
				in_escape_d        = 1'b0;
				seq_count_d        = 3'd0;
				res.has_evt        = 1'b1;
				res.evt.event_kind = dec.bad ? EVT_BREAK : EVT_KEY;
				res.evt.key_code   = dec.bad ? 8'h00 : dec.code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_cfg_q  <= TIMEOUT_RESET;
			in_escape_q    <= 1'b0;
			seq_count_q    <= 3'd0;
			timeout_left_q <= 8'd0;
		end else begin
			if (cfg_we) begin
				timeout_cfg_q <= cfg_wdata;
			end
			if (fire) begin
				in_escape_q    <= in_escape_d;
				seq_count_q    <= seq_count_d;
				timeout_left_q <= timeout_left_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && req.req_type == REQ_BYTE && in_escape_q && !count_bad) begin
			seq_bytes_q[wr_idx] <= req.rx_byte;
		end
	end

endmodule

>>> rtl/tekd_out_reg.sv
// tekd_out_reg: result register holding one key event until the sink takes it
// depends on tekd_pkg
module tekd_out_reg import tekd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  evt_t evt_in,
	output logic room,
	output logic out_valid,
	input  logic out_ready,
	output evt_t evt_out
);

	logic valid_q;
	evt_t evt_q;

	assign room      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign evt_out   = evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			evt_q <= evt_in;
		end
	end

endmodule

>>> rtl/terminal_escape_key_decoder_core.sv
// terminal_escape_key_decoder_core: terminal byte / tick requests in, key events out
// a request passes the input register, then its event is held in the result register
// throughput: one request per cycle while the event sink keeps ready high
// a request that yields no event still takes one pass through the decode stage
// reset: asynchronous, active low; idle, counters zero, timeout register back to 25 ticks
// depends on tekd_pkg, tekd_if, tekd_in_stage, tekd_decoder, tekd_out_reg
module terminal_escape_key_decoder_core import tekd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	tekd_req_if.sink         req,
	tekd_evt_if.source       evt
);

	req_t in_req;
	req_t req_s1;
	logic valid_s1;
	logic room;
	logic fire;
	res_t res;
	evt_t evt_s2;

	assign in_req.req_type = req.req_type;
	assign in_req.rx_byte  = req.rx_byte;
	assign fire            = valid_s1 && room;

	tekd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_req   (in_req),
		.advance  (room),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	tekd_decoder u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.req       (req_s1),
		.res       (res)
	);

	tekd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res.has_evt),
		.evt_in    (res.evt),
		.room      (room),
		.out_valid (evt.valid),
		.out_ready (evt.ready),
		.evt_out   (evt_s2)
	);

	assign evt.event_kind = evt_s2.event_kind;
	assign evt.key_code   = evt_s2.key_code;

endmodule
